// ===== hdl/fsb_pkg.sv =====
// Package: shared constants and beat widths of the first free signal bit finder.
package fsb_pkg;

  localparam int MAX_BYTES       = 64;
  localparam int MAX_SIGNAL_BITS = 64;
  localparam int MAP_BITS        = MAX_BYTES * 8;

  localparam int POS_W   = 9;   // bit position inside the map
  localparam int COUNT_W = 7;   // signal length field
  localparam int BYTES_W = 7;   // message length register
  localparam int SPAN_W  = 10;  // position plus length, may pass the map end

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  // Mirrors bit order inside a byte.
  localparam logic [POS_W-1:0] FLIP_MASK = 9'd7;

  localparam logic [COUNT_W-1:0] COUNT_SAT = COUNT_W'(MAX_SIGNAL_BITS);
  localparam logic [BYTES_W-1:0] BYTES_SAT = BYTES_W'(MAX_BYTES);
  localparam logic [BYTES_W-1:0] BYTES_RST = 7'd8;

endpackage

// ===== hdl/first_free_signal_bit_finder_unit.sv =====
// Top level: first free signal bit finder with occupancy map and priority search.
//
// The block collects the signals of one message frame, one signal per input
// beat, and marks the bits each one occupies in a 512-entry occupancy map held
// in flip-flops. A little-endian signal covers the file positions
// sig_start .. sig_start+bit_count-1, each mirrored inside its byte; a
// big-endian signal covers bit_count consecutive map positions from the
// mirrored sig_start. Anything past the map end is dropped. The beat with
// tlast set closes the frame: its own signal is marked first, then the block
// returns the mirrored index of the lowest unmarked position below
// message_bytes*8 (message_bytes saturates at 64), or 7 when every position
// is used, or 0 when message_bytes is 0. The map is cleared on the same edge,
// so the next frame may follow at once. One beat is taken every clock cycle
// unless the input stalls. The result of a closing beat passes through the
// input register, where the range mask is built and merged into the map,
// the snapshot register feeding the priority encoder, and then the output
// register. The input only stalls when a closing beat cannot move into the
// snapshot register because a result waits on the output side. message_bytes
// is written through cfg_wr_en/cfg_wr_data; the user must write it only while
// no frame is in flight, which the block does not enforce. It resets to 8.
// Reset is synchronous and clears the map at once, so no clearing pass is needed.
module first_free_signal_bit_finder_unit
  import fsb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // Input beats.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [8:0] sig_start, [15:9] bit_count, [16] little_endian, [17] signal_present,
  // [23:18] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tlast,   // last
  // Result beats.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [8:0] free_bit, [15:9] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // message_bytes register.
  input  logic                   cfg_wr_en,
  input  logic [BYTES_W-1:0]     cfg_wr_data
);

  // Configuration.
  logic [BYTES_W-1:0] message_bytes;

  // Occupancy map.
  logic [MAP_BITS-1:0] used_map;

  // Input register stage.
  logic               s1_valid;
  logic [POS_W-1:0]   s1_start;
  logic [COUNT_W-1:0] s1_count;
  logic               s1_little;
  logic               s1_present;
  logic               s1_last;

  // Snapshot stage: the closed frame's map and the length in force.
  logic                s2_valid;
  logic [MAP_BITS-1:0] s2_map;
  logic [BYTES_W-1:0]  s2_bytes;

  // Output register.
  logic [POS_W-1:0] free_bit;

  // Handshake chain.
  logic out_ready;
  logic s2_ready;
  logic s1_advance;

  // Stage 1 logic.
  logic [COUNT_W-1:0]  count_sat;
  logic [POS_W-1:0]    range_lo;
  logic [SPAN_W-1:0]   range_hi;
  logic [MAP_BITS-1:0] ge_mask;
  logic [MAP_BITS-1:0] lt_mask;
  logic [MAP_BITS-1:0] range_mask;
  logic [MAP_BITS-1:0] placed_mask;
  logic [MAP_BITS-1:0] merged_map;

  // Stage 2 logic.
  logic [BYTES_W-1:0]  bytes_sat;
  logic [SPAN_W-1:0]   limit;
  logic [MAP_BITS-1:0] limit_mask;
  logic [MAP_BITS-1:0] free_mask;
  logic [POS_W-1:0]    first_free;
  logic [POS_W-1:0]    free_bit_next;

  assign out_ready     = !m_axis_tvalid || m_axis_tready;
  assign s2_ready      = !s2_valid || out_ready;
  // A frame closer needs room in the snapshot stage; other beats only touch the map.
  assign s1_advance    = s1_valid && (!s1_last || s2_ready);
  assign s_axis_tready = !s1_valid || s1_advance;

  // Build the covered range, mirror it for little-endian signals, merge it.
  always_comb begin
    count_sat = (s1_count > COUNT_SAT) ? COUNT_SAT : s1_count;
    range_lo  = s1_little ? s1_start : (s1_start ^ FLIP_MASK);
    range_hi  = {1'b0, range_lo} + {{(SPAN_W-COUNT_W){1'b0}}, count_sat};
    ge_mask   = {MAP_BITS{1'b1}} << range_lo;
    // Positions past the map end are simply dropped.
    lt_mask   = range_hi[SPAN_W-1] ? {MAP_BITS{1'b1}}
                                   : ~({MAP_BITS{1'b1}} << range_hi[POS_W-1:0]);
    range_mask = ge_mask & lt_mask;
    for (int q = 0; q < MAP_BITS; q++) begin
      placed_mask[q] = s1_little ? range_mask[q ^ 7] : range_mask[q];
    end
    merged_map = s1_present ? (used_map | placed_mask) : used_map;
  end

  // Search the snapshot for the lowest free position below the limit.
  always_comb begin
    bytes_sat  = (s2_bytes > BYTES_SAT) ? BYTES_SAT : s2_bytes;
    limit      = {bytes_sat, 3'b000};
    limit_mask = limit[SPAN_W-1] ? {MAP_BITS{1'b1}}
                                 : ~({MAP_BITS{1'b1}} << limit[POS_W-1:0]);
    free_mask  = ~s2_map & limit_mask;
    first_free = '0;
    for (int p = MAP_BITS - 1; p >= 0; p--) begin
      if (free_mask[p]) begin
        first_free = POS_W'(p);
      end
    end
    // An empty message reports zero, not the mirrored zero.
    free_bit_next = (bytes_sat == '0) ? '0 : (first_free ^ FLIP_MASK);
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      message_bytes <= BYTES_RST;
    end else if (cfg_wr_en) begin
      message_bytes <= cfg_wr_data;
    end
  end

  // Input register: load on every accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_start   <= s_axis_tdata[8:0];
      s1_count   <= s_axis_tdata[15:9];
      s1_little  <= s_axis_tdata[16];
      s1_present <= s_axis_tdata[17];
      s1_last    <= s_axis_tlast;
    end
  end

  // Map update: merge the signal, or clear when the frame closes.
  always_ff @(posedge clk) begin
    if (rst) begin
      used_map <= '0;
    end else if (s1_advance) begin
      used_map <= s1_last ? '0 : merged_map;
    end
  end

  // Snapshot stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_advance && s1_last) begin
      s2_valid <= 1'b1;
    end else if (out_ready) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_last) begin
      s2_map   <= merged_map;
      s2_bytes <= message_bytes;
    end
  end

  // Output register: hold while the consumer stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_axis_tvalid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s2_valid) begin
      free_bit <= free_bit_next;
    end
  end

  assign m_axis_tdata = {{(OUT_TDATA_W-POS_W){1'b0}}, free_bit};

endmodule

// ===== hdl/fsb_checker.sv =====
// Checker: port-level properties of the first free signal bit finder, with bind.
module fsb_checker
  import fsb_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   s_axis_tlast,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // Closing beats taken but whose result is not yet delivered.
  logic [2:0] pending;
  logic       close_in;
  logic       result_out;

  assign close_in   = s_axis_tvalid && s_axis_tready && s_axis_tlast;
  assign result_out = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {2'b00, close_in} - {2'b00, result_out};
    end
  end

  // Reset empties the output.
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result beat present right after reset");

  // Every result belongs to an earlier closing beat.
  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> pending != 3'd0)
    else $error("result beat without a closing input beat");

  // At most three frames in flight: input, snapshot and output stages.
  a_depth: assert property (@(posedge clk) disable iff (rst) pending <= 3'd3)
    else $error("more closed frames in flight than stages");

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // Padding above free_bit stays zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:POS_W] == '0)
    else $error("result padding bits not zero");

endmodule

bind first_free_signal_bit_finder_unit fsb_checker u_fsb_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
